// File: rtl/core/ptt_pkg.sv
package ptt_pkg;

  // Default sizes of the slot table.
  localparam int unsigned SLOTS_DEF      = 16;
  localparam int unsigned DELAY_BITS_DEF = 16;
  localparam int unsigned ID_BITS_DEF    = 8;

  // Fixed field widths on the stream ports.
  localparam int unsigned OP_W    = 2;
  localparam int unsigned TASK_W  = 8;
  localparam int unsigned DLY_W   = 16;
  localparam int unsigned REP_W   = 16;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned SLOT_W  = 6;
  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 16;

  // At most this many results are reported for one item.
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;
  localparam logic [OP_W-1:0] OP_POLL  = 2'd3;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_FIRED   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STARTED = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FULL    = 2'd2;

  // Status of the slot unit for the slot under evaluation.
  typedef struct packed {
    logic fire;
    logic active;
    logic match;
  } slot_flags_t;

endpackage

// File: rtl/core/ptt_ram.sv
module ptt_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                     clk_i,
  input  logic                                     wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]                         wr_data_i,
  input  logic                                     rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]                         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// File: rtl/core/ptt_slot_unit.sv
module ptt_slot_unit #(
  parameter int unsigned DELAY_BITS = ptt_pkg::DELAY_BITS_DEF,
  parameter int unsigned ID_BITS    = ptt_pkg::ID_BITS_DEF
) (
  input  logic [ptt_pkg::OP_W-1:0]         op_i,
  input  logic [ID_BITS-1:0]               id_i,
  input  logic [ID_BITS-1:0]               owner_i,
  input  logic [DELAY_BITS-1:0]            reload_i,
  input  logic [DELAY_BITS-1:0]            remaining_i,
  input  logic signed [ptt_pkg::REP_W-1:0] repeats_i,
  output logic [DELAY_BITS-1:0]            remaining_o,
  output logic signed [ptt_pkg::REP_W-1:0] repeats_o,
  output ptt_pkg::slot_flags_t             flags_o
);

  import ptt_pkg::*;

  logic                    active;
  logic                    rem_zero;
  logic                    is_tick;
  logic                    is_poll;
  logic                    fire;
  logic [DELAY_BITS-1:0]   rem_dec;
  logic signed [REP_W-1:0] rep_next;

  assign active   = (repeats_i != '0);
  assign rem_zero = (remaining_i == '0);
  assign is_tick  = (op_i == OP_TICK);
  assign is_poll  = (op_i == OP_POLL);
  assign rem_dec  = remaining_i - DELAY_BITS'(1);

  // A tick fires a slot that counts down from one; a poll fires a slot already at zero.
  assign fire = active && ((is_tick && (remaining_i == DELAY_BITS'(1))) ||
                           (is_poll && rem_zero));

  // A positive count uses up one repeat; a negative count repeats forever.
  assign rep_next = (repeats_i > 0) ? (repeats_i - REP_W'(1)) : repeats_i;

  // Count down, then reload on a firing that leaves repeats.
  always_comb begin
    remaining_o = remaining_i;
    repeats_o   = repeats_i;
    if (active && is_tick && !rem_zero) begin
      remaining_o = rem_dec;
    end
    if (fire) begin
      repeats_o = rep_next;
      if (rep_next != '0) begin
        remaining_o = reload_i;
      end
    end
  end

  assign flags_o.fire   = fire;
  assign flags_o.active = active;
  assign flags_o.match  = (owner_i == id_i);

endmodule

// File: rtl/core/periodic_task_timer_table.sv
// Periodic task timer table. Each item (tuser selects tick, start, stop or poll) walks
// the whole slot table once through one shared slot unit, one slot per cycle except
// while a fire result waits on a stalled output, out of a single-port-read slot
// memory; a start then passes through a further state that writes any new entry. Start
// gives one result (started or table full) with tlast; stop gives none; tick and poll
// give one fire result per firing slot in slot order, the final one with tlast, capped
// at MAX_RESULTS results per item. The input is not ready while an item is being worked
// on, but the next item is taken while a finished result still waits in the output
// register. Slot entries never written read as zero, so no clearing pass is needed
// after reset.
module periodic_task_timer_table #(
  parameter int unsigned SLOTS      = ptt_pkg::SLOTS_DEF,
  parameter int unsigned DELAY_BITS = ptt_pkg::DELAY_BITS_DEF,
  parameter int unsigned ID_BITS    = ptt_pkg::ID_BITS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // task_id [7:0], delay_ticks [23:8], repeat_count [39:24]
  input  logic [ptt_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // opcode [1:0]
  input  logic [ptt_pkg::OP_W-1:0]           s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // fired_task [7:0], slot_index [13:8], zero [15:14]
  output logic [ptt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  // kind [1:0]
  output logic [ptt_pkg::KIND_W-1:0]         m_axis_tuser,
  output logic                               m_axis_tlast
);

  import ptt_pkg::*;

  localparam int unsigned IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned ENTRY_W = ID_BITS + 2 * DELAY_BITS + REP_W;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WALK  = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [OP_W-1:0]         op_q, op_d;
  logic [ID_BITS-1:0]      id_q, id_d;
  logic [DELAY_BITS-1:0]   dly_q, dly_d;
  logic [REP_W-1:0]        rc_q, rc_d;
  logic [IDX_W-1:0]        idx_q, idx_d;
  logic                    hit_found_q, hit_found_d;
  logic [IDX_W-1:0]        hit_idx_q, hit_idx_d;
  logic                    empty_found_q, empty_found_d;
  logic [IDX_W-1:0]        empty_idx_q, empty_idx_d;
  logic                    stop_done_q, stop_done_d;
  logic [RES_CNT_W-1:0]    res_cnt_q, res_cnt_d;

  logic                    pend_valid_q, pend_valid_d;
  logic [KIND_W-1:0]       pend_kind_q, pend_kind_d;
  logic [TASK_W-1:0]       pend_task_q, pend_task_d;
  logic [SLOT_W-1:0]       pend_slot_q, pend_slot_d;

  logic                    out_valid_q, out_valid_d;
  logic [KIND_W-1:0]       out_kind_q, out_kind_d;
  logic [TASK_W-1:0]       out_task_q, out_task_d;
  logic [SLOT_W-1:0]       out_slot_q, out_slot_d;
  logic                    out_last_q, out_last_d;

  logic [SLOTS-1:0]        vld_q, vld_d;
  logic                    rdv_q;

  logic                    in_xfer;
  logic                    out_free;
  logic                    rd_en;
  logic [IDX_W-1:0]        rd_addr;
  logic                    wr_en;
  logic [IDX_W-1:0]        wr_addr;
  logic [ENTRY_W-1:0]      wr_data;
  logic [ENTRY_W-1:0]      rd_raw;
  logic [ENTRY_W-1:0]      entry;

  logic [ID_BITS-1:0]      ent_owner;
  logic [DELAY_BITS-1:0]   ent_reload;
  logic [DELAY_BITS-1:0]   ent_rem;
  logic signed [REP_W-1:0] ent_rep;
  logic [DELAY_BITS-1:0]   new_rem;
  logic signed [REP_W-1:0] new_rep;
  slot_flags_t             flags;

  logic                    is_timer;
  logic                    last_slot;
  logic                    want_emit;
  logic                    stall;
  logic                    advance;
  logic                    sel_found;
  logic [IDX_W-1:0]        sel_idx;

  // Slot memory: entry is {repeats, remaining, reload, owner}.
  ptt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_raw)
  );

  // Entries never written read as the reset value of zero.
  assign entry      = rdv_q ? rd_raw : '0;
  assign ent_owner  = entry[ID_BITS-1:0];
  assign ent_reload = entry[ID_BITS +: DELAY_BITS];
  assign ent_rem    = entry[ID_BITS + DELAY_BITS +: DELAY_BITS];
  assign ent_rep    = entry[ID_BITS + 2 * DELAY_BITS +: REP_W];

  ptt_slot_unit #(
    .DELAY_BITS (DELAY_BITS),
    .ID_BITS    (ID_BITS)
  ) u_slot (
    .op_i        (op_q),
    .id_i        (id_q),
    .owner_i     (ent_owner),
    .reload_i    (ent_reload),
    .remaining_i (ent_rem),
    .repeats_i   (ent_rep),
    .remaining_o (new_rem),
    .repeats_o   (new_rep),
    .flags_o     (flags)
  );

  // Handshake and walk control.
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign out_free  = !out_valid_q || m_axis_tready;
  assign is_timer  = (op_q == OP_TICK) || (op_q == OP_POLL);
  assign last_slot = (idx_q == IDX_W'(SLOTS - 1));
  assign want_emit = (state_q == ST_WALK) && is_timer && flags.fire &&
                     (res_cnt_q < RES_CNT_W'(MAX_RESULTS));
  assign stall     = want_emit && pend_valid_q && !out_free;
  assign advance   = (state_q == ST_WALK) && !stall;
  assign rd_en     = in_xfer || (advance && !last_slot);
  assign rd_addr   = in_xfer ? '0 : (idx_q + IDX_W'(1));
  assign sel_found = hit_found_q || empty_found_q;
  assign sel_idx   = hit_found_q ? hit_idx_q : empty_idx_q;

  // Write port: timer update or stop during the walk, new entry after a start scan.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = idx_q;
    wr_data = {new_rep, new_rem, ent_reload, ent_owner};
    if (advance && is_timer && flags.active) begin
      wr_en = 1'b1;
    end else if (advance && (op_q == OP_STOP) && flags.match && !stop_done_q) begin
      wr_en   = 1'b1;
      wr_data = {REP_W'(0), ent_rem, ent_reload, ent_owner};
    end else if ((state_q == ST_START) && sel_found) begin
      wr_en   = 1'b1;
      wr_addr = sel_idx;
      wr_data = {rc_q, dly_q, dly_q, id_q};
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // Sequencer over the slots.
  always_comb begin
    state_d       = state_q;
    op_d          = op_q;
    id_d          = id_q;
    dly_d         = dly_q;
    rc_d          = rc_q;
    idx_d         = idx_q;
    hit_found_d   = hit_found_q;
    hit_idx_d     = hit_idx_q;
    empty_found_d = empty_found_q;
    empty_idx_d   = empty_idx_q;
    stop_done_d   = stop_done_q;
    res_cnt_d     = res_cnt_q;
    pend_valid_d  = pend_valid_q;
    pend_kind_d   = pend_kind_q;
    pend_task_d   = pend_task_q;
    pend_slot_d   = pend_slot_q;
    out_valid_d   = out_valid_q && !m_axis_tready;
    out_kind_d    = out_kind_q;
    out_task_d    = out_task_q;
    out_slot_d    = out_slot_q;
    out_last_d    = out_last_q;
    vld_d         = vld_q;

    if (wr_en) begin
      vld_d[wr_addr] = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          op_d          = s_axis_tuser;
          id_d          = ID_BITS'(s_axis_tdata[TASK_W-1:0]);
          dly_d         = DELAY_BITS'(s_axis_tdata[TASK_W +: DLY_W]);
          rc_d          = s_axis_tdata[TASK_W + DLY_W +: REP_W];
          idx_d         = '0;
          hit_found_d   = 1'b0;
          empty_found_d = 1'b0;
          stop_done_d   = 1'b0;
          res_cnt_d     = '0;
          state_d       = ST_WALK;
        end
      end
      ST_WALK: begin
        if (advance) begin
          // Start scan: first owner match and first inactive slot.
          if (flags.match && !hit_found_q) begin
            hit_found_d = 1'b1;
            hit_idx_d   = idx_q;
          end
          if (!flags.active && !empty_found_q) begin
            empty_found_d = 1'b1;
            empty_idx_d   = idx_q;
          end
          if ((op_q == OP_STOP) && flags.match) begin
            stop_done_d = 1'b1;
          end
          // A new fire pushes the held one out, which is then known not to be last.
          if (want_emit) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_kind_d  = pend_kind_q;
              out_task_d  = pend_task_q;
              out_slot_d  = pend_slot_q;
              out_last_d  = 1'b0;
            end
            pend_valid_d = 1'b1;
            pend_kind_d  = KIND_FIRED;
            pend_task_d  = TASK_W'(ent_owner);
            pend_slot_d  = SLOT_W'(idx_q);
            res_cnt_d    = res_cnt_q + RES_CNT_W'(1);
          end
          idx_d = idx_q + IDX_W'(1);
          if (last_slot) begin
            idx_d   = idx_q;
            state_d = (op_q == OP_START) ? ST_START : ST_FLUSH;
          end
        end
      end
      ST_START: begin
        pend_valid_d = 1'b1;
        if (sel_found) begin
          pend_kind_d = KIND_STARTED;
          pend_task_d = TASK_W'(id_q);
          pend_slot_d = SLOT_W'(sel_idx);
        end else begin
          pend_kind_d = KIND_FULL;
          pend_task_d = '0;
          pend_slot_d = '0;
        end
        state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        // The held result is the final one of this item.
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_kind_d   = pend_kind_q;
          out_task_d   = pend_task_q;
          out_slot_d   = pend_slot_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      hit_found_q   <= 1'b0;
      empty_found_q <= 1'b0;
      stop_done_q   <= 1'b0;
      res_cnt_q     <= '0;
      pend_valid_q  <= 1'b0;
      out_valid_q   <= 1'b0;
      vld_q         <= '0;
      rdv_q         <= 1'b0;
    end else begin
      state_q       <= state_d;
      hit_found_q   <= hit_found_d;
      empty_found_q <= empty_found_d;
      stop_done_q   <= stop_done_d;
      res_cnt_q     <= res_cnt_d;
      pend_valid_q  <= pend_valid_d;
      out_valid_q   <= out_valid_d;
      vld_q         <= vld_d;
      if (rd_en) begin
        rdv_q <= vld_q[rd_addr];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    id_q        <= id_d;
    dly_q       <= dly_d;
    rc_q        <= rc_d;
    idx_q       <= idx_d;
    hit_idx_q   <= hit_idx_d;
    empty_idx_q <= empty_idx_d;
    pend_kind_q <= pend_kind_d;
    pend_task_q <= pend_task_d;
    pend_slot_q <= pend_slot_d;
    out_kind_q  <= out_kind_d;
    out_task_q  <= out_task_d;
    out_slot_q  <= out_slot_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OUT_DATA_W - TASK_W - SLOT_W)'(0), out_slot_q, out_task_q};
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// File: rtl/core/ptt_checker.sv
module ptt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [ptt_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  input logic [ptt_pkg::KIND_W-1:0]     m_axis_tuser,
  input logic                           m_axis_tlast
);

  import ptt_pkg::*;

  // A stalled result transfer keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
      $stable(m_axis_tlast))
    else $error("result changed while stalled");

  // The block works on one item at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input ready right after an accepted item");

  // A full table reports zero id and slot, and it is the only result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_FULL) |->
      (m_axis_tdata == '0) && m_axis_tlast)
    else $error("bad table full result");

  // A start gives exactly one result, so it is always marked last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == KIND_STARTED) |-> m_axis_tlast)
    else $error("start result without last mark");

endmodule

bind periodic_task_timer_table ptt_checker u_ptt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: sim/tb_top.sv
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ptt_pkg::*;

  localparam int unsigned NUM_SLOTS   = SLOTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 500_000;
  localparam int unsigned TAIL_CYCLES = 40;

  // One result as the block should report it.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TASK_W-1:0] task_id;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } timer_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // task_id [7:0], delay_ticks [23:8], repeat_count [39:24]
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  // opcode [1:0]
  logic [OP_W-1:0]       s_axis_tuser = OP_TICK;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // fired_task [7:0], slot_index [13:8], zero [15:14]
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // kind [1:0]
  logic [KIND_W-1:0]     m_axis_tuser;
  logic                  m_axis_tlast;

  // Shadow copy of the slot table.
  logic        [TASK_W-1:0] owner_id     [NUM_SLOTS];
  logic        [DLY_W-1:0]  reload_ticks [NUM_SLOTS];
  logic        [DLY_W-1:0]  remain_ticks [NUM_SLOTS];
  logic signed [REP_W-1:0]  repeats_left [NUM_SLOTS];

  timer_result_t expected_results[$];
  timer_result_t next_result;

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  int unsigned snd_idle_pct = 17;
  int unsigned rcv_stall_pct = 61;

  periodic_task_timer_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Clock with a 20 ns period.
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver back-pressure.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  // Apply one item to the shadow table and queue the results it causes.
  task automatic predict_timer_item(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] id,
                                    input logic [DLY_W-1:0] dly,
                                    input logic signed [REP_W-1:0] rep);
    int            hit;
    int            empty;
    bit            fire;
    timer_result_t res;
    timer_result_t fired[$];
    hit = -1;
    empty = -1;
    case (op)
      OP_START: begin
        // An owner match anywhere wins over an earlier inactive slot.
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (hit < 0) begin
            if (owner_id[i] == id) begin
              hit = i;
            end else if (empty < 0 && repeats_left[i] == 0) begin
              empty = i;
            end
          end
        end
        if (hit < 0 && empty >= 0) begin
          hit = empty;
          owner_id[hit] = id;
        end
        if (hit < 0) begin
          res = '{kind: KIND_FULL, task_id: '0, slot: '0, last: 1'b1};
        end else begin
          remain_ticks[hit] = dly;
          reload_ticks[hit] = dly;
          repeats_left[hit] = rep;
          res = '{kind: KIND_STARTED, task_id: id, slot: SLOT_W'(hit), last: 1'b1};
        end
        expected_results.push_back(res);
      end
      OP_STOP: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (hit < 0 && owner_id[i] == id) begin
            hit = i;
            repeats_left[i] = '0;
          end
        end
      end
      default: begin
        // Tick counts active slots down; poll fires active slots already at zero.
        for (int i = 0; i < NUM_SLOTS; i++) begin
          fire = 1'b0;
          if (repeats_left[i] != 0) begin
            if (op == OP_TICK) begin
              if (remain_ticks[i] != 0) begin
                remain_ticks[i] = remain_ticks[i] - 1'b1;
                fire = (remain_ticks[i] == 0);
              end
            end else begin
              fire = (remain_ticks[i] == 0);
            end
          end
          if (fire) begin
            if (repeats_left[i] > 0) repeats_left[i] = repeats_left[i] - 1'b1;
            if (repeats_left[i] != 0) remain_ticks[i] = reload_ticks[i];
            if (fired.size() < MAX_RESULTS) begin
              fired.push_back('{kind: KIND_FIRED, task_id: owner_id[i],
                                slot: SLOT_W'(i), last: 1'b0});
            end
          end
        end
        if (fired.size() > 0) fired[fired.size()-1].last = 1'b1;
        foreach (fired[k]) expected_results.push_back(fired[k]);
      end
    endcase
  endtask

  // Offer one item with an optional idle gap ahead of it and wait for its transfer.
  task automatic send_timer_item(input logic [OP_W-1:0] op, input logic [TASK_W-1:0] id,
                                 input logic [DLY_W-1:0] dly, input logic [REP_W-1:0] rep);
    if ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {rep, dly, id};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_timer_item(op, id, dly, rep);
  endtask

  // Hold the input off until every queued result has been seen.
  task automatic wait_results_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (expected_results.size() != 0);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: kind %0d, fired_task %0d, slot_index %0d, last %0d",
               m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8], m_axis_tlast);
        error_count++;
      end else begin
        next_result = expected_results.pop_front();
        check_field("kind", next_result.kind, m_axis_tuser);
        check_field("fired_task", next_result.task_id, m_axis_tdata[7:0]);
        check_field("slot_index", next_result.slot, m_axis_tdata[13:8]);
        check_field("last", next_result.last, m_axis_tlast);
        check_field("tdata padding", 0, m_axis_tdata[15:14]);
      end
    end
  end

  // Periodic firing, reload, and the end of a finite repeat count.
  task automatic test_fire_and_reload();
    send_timer_item(OP_START, 8'h01, 16'd2, 16'sd2);
    send_timer_item(OP_TICK, 8'hA5, 16'h5A5A, 16'h0F0F);
    send_timer_item(OP_TICK, 8'h00, 16'd0, 16'd0);
    // A zero delay with a forever count only fires on poll.
    send_timer_item(OP_START, 8'hFF, 16'd0, -16'sd1);
    send_timer_item(OP_POLL, 8'h5A, 16'hA5A5, 16'hF0F0);
    send_timer_item(OP_TICK, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_timer_item(OP_TICK, 8'h00, 16'd0, 16'd0);
  endtask

  // Owner matching, a zero repeat count, id zero, and stop.
  task automatic test_start_matching_and_stop();
    send_timer_item(OP_START, 8'h01, 16'd5, 16'sd0);
    // Id zero matches a never-used slot even past an inactive one.
    send_timer_item(OP_START, 8'h00, 16'hFFFF, 16'sh7FFF);
    send_timer_item(OP_STOP, 8'h77, 16'd0, 16'd0);
    send_timer_item(OP_STOP, 8'hFF, 16'd0, 16'd0);
    send_timer_item(OP_POLL, 8'h00, 16'd0, 16'd0);
  endtask

  // Fill every free slot, hit the full table, then let them all fire at once.
  task automatic test_table_full();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      send_timer_item(OP_START, TASK_W'(8'h20 + i), 16'd1, 16'sh8000);
    end
    send_timer_item(OP_TICK, 8'h00, 16'd0, 16'd0);
  endtask

  // Mostly well-formed traffic over a small id pool, with some fully random noise.
  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int unsigned num_items);
    logic [OP_W-1:0]   op;
    logic [TASK_W-1:0] id;
    logic [DLY_W-1:0]  dly;
    logic [REP_W-1:0]  rep;
    int unsigned       pick;
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    for (int n = 0; n < num_items; n++) begin
      pick = $urandom_range(99);
      if (pick < 40)      op = OP_TICK;
      else if (pick < 70) op = OP_START;
      else if (pick < 85) op = OP_STOP;
      else                op = OP_POLL;
      id = ($urandom_range(9) == 0) ? TASK_W'($urandom) : TASK_W'($urandom_range(47, 1));
      case ($urandom_range(9))
        0:       dly = DLY_W'($urandom);
        1:       dly = '1;
        default: dly = DLY_W'($urandom_range(6));
      endcase
      case ($urandom_range(9))
        0:       rep = REP_W'($urandom);
        1:       rep = ($urandom_range(1)) ? 16'h7FFF : 16'h8000;
        default: rep = REP_W'($urandom_range(7)) - 16'd2;
      endcase
      send_timer_item(op, id, dly, rep);
    end
  endtask

  initial begin
    foreach (owner_id[i]) begin
      owner_id[i]     = '0;
      reload_ticks[i] = '0;
      remain_ticks[i] = '0;
      repeats_left[i] = '0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_fire_and_reload();
    test_start_matching_and_stop();
    test_table_full();
    wait_results_drained();

    test_random_traffic(17, 61, 80);
    wait_results_drained();
    test_random_traffic(61, 17, 80);
    wait_results_drained();
    test_random_traffic(0, 0, 80);

    // Let the last item finish and any stray result show up.
    wait_results_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      $error("%0d expected results never arrived", expected_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
rtl/core/ptt_pkg.sv
rtl/core/ptt_ram.sv
rtl/core/ptt_slot_unit.sv
rtl/core/periodic_task_timer_table.sv
rtl/core/ptt_checker.sv
sim/tb_top.sv
